// File: hw/rtl/cltq_pkg.sv
// cltq_pkg: shared types and constants for the circular linked task queue
// command and result beat structs, operation codes, link table control
// no dependencies
package cltq_pkg;

	localparam int TASK_W    = 4;
	localparam int COUNT_W   = 5;
	localparam int NUM_TASKS = 16;

	typedef enum logic {
		FUNC_APPEND = 1'b0,
		FUNC_REMOVE = 1'b1
	} func_t;

	typedef enum logic {
		STATUS_DONE   = 1'b0,
		STATUS_REJECT = 1'b1
	} status_t;

	typedef struct packed {
		func_t             func;
		logic [TASK_W-1:0] task_id;
	} cmd_beat_t;

	typedef struct packed {
		status_t            status;
		logic [TASK_W-1:0]  task_echo;
		logic [COUNT_W-1:0] queue_count;
		logic [TASK_W-1:0]  head_task;
		logic               head_valid;
	} rsp_beat_t;

	typedef struct packed {
		logic  wr_en;
		func_t op;
		logic  empty;
		logic  solo;
	} link_ctl_t;

endpackage

// File: hw/rtl/cltq_link_tbl.sv
// cltq_link_tbl: next and prev pointer tables of the circular queue
// reads the links of the addressed task, applies append and unlink writes
// depends on cltq_pkg
module cltq_link_tbl #(
	parameter int NUM_TASKS = cltq_pkg::NUM_TASKS,
	localparam int PW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1
) (
	input  logic                clk,
	input  cltq_pkg::link_ctl_t ctl,
	input  logic [PW-1:0]       tid,
	input  logic [PW-1:0]       head,
	input  logic [PW-1:0]       tail,
	output logic [PW-1:0]       nxt,
	output logic [PW-1:0]       prv
);

	logic [PW-1:0] next_q [NUM_TASKS];
	logic [PW-1:0] prev_q [NUM_TASKS];

	assign nxt = next_q[tid];
	assign prv = prev_q[tid];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			if (ctl.op == cltq_pkg::FUNC_APPEND) begin
				if (ctl.empty) begin
					next_q[tid] <= tid;
					prev_q[tid] <= tid;
				end else begin
					next_q[tid]  <= head;
					prev_q[tid]  <= tail;
					next_q[tail] <= tid;
					prev_q[head] <= tid;
				end
			end else if (!ctl.solo) begin
				// unlink: neighbors point past the removed task
				next_q[prv] <= nxt;
				prev_q[nxt] <= prv;
			end
		end
	end

endmodule

// File: hw/rtl/circular_linked_task_queue_core.sv
// circular_linked_task_queue_core: top level of the circular linked task queue
// command register, membership and head/tail/count state, result register
// depends on cltq_pkg and cltq_link_tbl
//
// Usage: a command beat (append a task at the tail, or remove a named task)
// is taken at a rising edge with start high and busy low. busy is never
// raised, so one command can be taken every cycle. The command is held in an
// input register while the membership bits and the link table row of the
// task decide the outcome; the state and the result register are written at
// the next edge. done is high for exactly one cycle, registered from the
// input stage valid flag, and the result beat on rsp is taken at the edge
// that ends it. Sustained rate: one command per cycle, through the input
// and result registers around the link update. The receiver cannot hold
// results off. Every command gives one result with status, the task, the
// count after the operation and the head. Rejected commands (duplicate
// append, remove of a non-member or from an empty queue, task id beyond the
// pool) leave the state unchanged. Reset empties the queue: no members,
// head zero, count zero.
module circular_linked_task_queue_core #(
	parameter int NUM_TASKS = cltq_pkg::NUM_TASKS,
	localparam int PW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1,
	localparam int CW = $clog2(NUM_TASKS + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  cltq_pkg::cmd_beat_t cmd,
	output logic                done,
	output cltq_pkg::rsp_beat_t rsp
);

	logic                valid_s1;
	cltq_pkg::cmd_beat_t cmd_s1;

	logic [NUM_TASKS-1:0] member_q, member_nxt;
	logic [PW-1:0]        head_q, head_nxt;
	logic [PW-1:0]        tail_q, tail_nxt;
	logic                 nonempty_q, nonempty_nxt;
	logic [CW-1:0]        count_q, count_nxt;
	logic                 done_q;
	cltq_pkg::rsp_beat_t  rsp_q, rsp_nxt;

	logic                tid_ok, is_mem, app_ok, rem_ok, solo;
	logic [PW-1:0]       idx, link_nxt, link_prv;
	cltq_pkg::link_ctl_t link_ctl;

	assign busy = 1'b0;
	assign done = done_q;
	assign rsp  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1 <= cmd;
		end
	end

	assign idx    = PW'(cmd_s1.task_id);
	assign tid_ok = valid_s1 && (int'(cmd_s1.task_id) < NUM_TASKS);
	assign is_mem = tid_ok && member_q[idx];
	assign solo   = (count_q == CW'(1));
	assign app_ok = tid_ok && (cmd_s1.func == cltq_pkg::FUNC_APPEND) && !is_mem;
	assign rem_ok = is_mem && nonempty_q && (cmd_s1.func == cltq_pkg::FUNC_REMOVE);

	always_comb begin
		link_ctl.wr_en = app_ok || rem_ok;
		link_ctl.op    = cmd_s1.func;
		link_ctl.empty = !nonempty_q;
		link_ctl.solo  = solo;
	end

	cltq_link_tbl #(
		.NUM_TASKS(NUM_TASKS)
	) u_link_tbl (
		.clk (clk),
		.ctl (link_ctl),
		.tid (idx),
		.head(head_q),
		.tail(tail_q),
		.nxt (link_nxt),
		.prv (link_prv)
	);

	always_comb begin
		member_nxt   = member_q;
		head_nxt     = head_q;
		tail_nxt     = tail_q;
		nonempty_nxt = nonempty_q;
		count_nxt    = count_q;
		if (app_ok) begin
			member_nxt[idx] = 1'b1;
			tail_nxt        = idx;
			nonempty_nxt    = 1'b1;
			count_nxt       = count_q + CW'(1);
			if (!nonempty_q) begin
				head_nxt = idx;
			end
		end else if (rem_ok) begin
			member_nxt[idx] = 1'b0;
			if (solo) begin
				head_nxt     = '0;
				tail_nxt     = '0;
				nonempty_nxt = 1'b0;
				count_nxt    = '0;
			end else begin
				count_nxt = count_q - CW'(1);
				if (head_q == idx) begin
					head_nxt = link_nxt;
				end
				if (tail_q == idx) begin
					tail_nxt = link_prv;
				end
			end
		end
	end

	always_comb begin
		rsp_nxt.status      = (app_ok || rem_ok) ? cltq_pkg::STATUS_DONE
		                                         : cltq_pkg::STATUS_REJECT;
		rsp_nxt.task_echo   = cmd_s1.task_id;
		rsp_nxt.queue_count = cltq_pkg::COUNT_W'(count_nxt);
		rsp_nxt.head_task   = nonempty_nxt ? cltq_pkg::TASK_W'(head_nxt) : '0;
		rsp_nxt.head_valid  = nonempty_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			member_q   <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			nonempty_q <= 1'b0;
			count_q    <= '0;
			done_q     <= 1'b0;
		end else begin
			member_q   <= member_nxt;
			head_q     <= head_nxt;
			tail_q     <= tail_nxt;
			nonempty_q <= nonempty_nxt;
			count_q    <= count_nxt;
			done_q     <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rsp_q <= rsp_nxt;
		end
	end

	a_count_matches_members: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(member_q) == int'(count_q))
		else $error("member count differs from running count");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		nonempty_q == (count_q != '0))
		else $error("nonempty flag differs from count");

	a_head_is_member: assert property (@(posedge clk) disable iff (!arst_n)
		nonempty_q |-> member_q[head_q])
		else $error("head task is not queued");

	a_tail_is_member: assert property (@(posedge clk) disable iff (!arst_n)
		nonempty_q |-> member_q[tail_q])
		else $error("tail task is not queued");

	a_append_done_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == cltq_pkg::STATUS_DONE
			&& $past(cmd_s1.func) == cltq_pkg::FUNC_APPEND) |-> rsp.head_valid)
		else $error("accepted append left the queue empty");

endmodule
